/* hw/rtl/cprf_pkg.sv */
package cprf_pkg;

  // Width of the run counter; a run closes once it holds 2**RunLenBits mappings.
  localparam int unsigned RunLenBits = 16;

  localparam int unsigned CodeW  = 24;
  localparam int unsigned GlyphW = 17;
  localparam int unsigned LenW   = 16;

  // Output queue: two records may enter per beat, one leaves.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [CodeW-1:0]  start_code;
    logic [GlyphW-1:0] start_glyph;
    logic [LenW-1:0]   length_minus_one;
    logic              last_run;
  } rec_t;

endpackage

/* hw/rtl/code_point_run_folder.sv */
// Folds a stream of character-to-glyph mappings, sorted by code point, into
// run records: each run of mappings where code point and glyph index both
// rise by one becomes one record (start code, start glyph, length minus one).
// Input channel: in_valid_i / in_stall_o carry one mapping per beat, with
// last_item_i marking the end of a list. Output channel: out_valid_o /
// out_stall_i carry one record per beat, last_run_o on the final record.
// A beat is taken whenever valid is high and stall is low.
// A mapping is compared against the previous one in the cycle it is taken,
// so one mapping is accepted every cycle while in_stall_o is low. The
// records it closes (zero, one, or two when a break and the end of a list
// coincide) are written into a four-entry output queue and reach the output
// once the records ahead of them have left. The queue drains one record
// per cycle while out_stall_i is low; in_stall_o rises when fewer than two
// queue slots are free. When the receiver stalls, the queue fills and then
// the input is stalled; the output record holds steady while stalled.
// Reset empties the queue and clears the open run, so the next mapping
// begins a new list.
module code_point_run_folder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] code_point_i,
  input  logic [16:0] glyph_index_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] start_code_o,
  output logic [16:0] start_glyph_o,
  output logic [15:0] length_minus_one_o,
  output logic        last_run_o
);

  // Run state.
  logic                               run_open_q, run_open_d;
  logic [cprf_pkg::CodeW-1:0]         base_code_q, base_code_d;
  logic [cprf_pkg::GlyphW-1:0]        base_glyph_q, base_glyph_d;
  logic [cprf_pkg::CodeW-1:0]         prev_code_q;
  logic [cprf_pkg::GlyphW-1:0]        prev_glyph_q;
  logic [cprf_pkg::RunLenBits-1:0]    run_count_q, run_count_d;

  // Output queue.
  cprf_pkg::rec_t                     queue_q [cprf_pkg::QDepth];
  logic [cprf_pkg::QPtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [cprf_pkg::QCntW-1:0]         count_q;

  logic                               in_fire, out_fire, extend;
  logic                               push_brk, push_last;
  cprf_pkg::rec_t                     brk_rec, last_rec;
  logic [cprf_pkg::QPtrW-1:0]         last_slot;
  logic [cprf_pkg::QCntW-1:0]         n_push;

  assign in_stall_o = count_q > cprf_pkg::QCntW'(cprf_pkg::QDepth - 2);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_fire   = out_valid_o && !out_stall_i;

  // A run continues only when both keys step by exactly one. The increment is
  // one bit wider so that the top of either range never wraps into a match.
  assign extend = run_open_q &&
                  ({1'b0, code_point_i} == {1'b0, prev_code_q} + 25'd1) &&
                  ({1'b0, glyph_index_i} == {1'b0, prev_glyph_q} + 18'd1) &&
                  !(&run_count_q);

  always_comb begin
    base_code_d  = base_code_q;
    base_glyph_d = base_glyph_q;
    run_count_d  = run_count_q;
    run_open_d   = run_open_q;
    if (extend) begin
      run_count_d = run_count_q + 1'b1;
    end else begin
      run_open_d   = 1'b1;
      base_code_d  = code_point_i;
      base_glyph_d = glyph_index_i;
      run_count_d  = '0;
    end
    if (last_item_i) begin
      run_open_d = 1'b0;
    end
  end

  // The broken run goes first, then the run holding a last item.
  assign push_brk  = in_fire && run_open_q && !extend;
  assign push_last = in_fire && last_item_i;

  assign brk_rec.start_code       = base_code_q;
  assign brk_rec.start_glyph      = base_glyph_q;
  assign brk_rec.length_minus_one = cprf_pkg::LenW'(run_count_q);
  assign brk_rec.last_run         = 1'b0;

  assign last_rec.start_code       = base_code_d;
  assign last_rec.start_glyph      = base_glyph_d;
  assign last_rec.length_minus_one = cprf_pkg::LenW'(run_count_d);
  assign last_rec.last_run         = 1'b1;

  assign last_slot = push_brk ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign n_push    = cprf_pkg::QCntW'(push_brk) + cprf_pkg::QCntW'(push_last);

  always_ff @(posedge clk_i) begin
    if (push_brk) begin
      queue_q[wr_ptr_q] <= brk_rec;
    end
    if (push_last) begin
      queue_q[last_slot] <= last_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      base_code_q  <= '0;
      base_glyph_q <= '0;
      prev_code_q  <= '0;
      prev_glyph_q <= '0;
      run_count_q  <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
    end else begin
      if (in_fire) begin
        run_open_q   <= run_open_d;
        base_code_q  <= base_code_d;
        base_glyph_q <= base_glyph_d;
        prev_code_q  <= code_point_i;
        prev_glyph_q <= glyph_index_i;
        run_count_q  <= run_count_d;
      end
      wr_ptr_q <= wr_ptr_q + cprf_pkg::QPtrW'(n_push);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + n_push - cprf_pkg::QCntW'(out_fire);
    end
  end

  assign start_code_o       = queue_q[rd_ptr_q].start_code;
  assign start_glyph_o      = queue_q[rd_ptr_q].start_glyph;
  assign length_minus_one_o = queue_q[rd_ptr_q].length_minus_one;
  assign last_run_o         = queue_q[rd_ptr_q].last_run;

`ifndef ASSERT_OFF
  // The queue never holds more records than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cprf_pkg::QCntW'(cprf_pkg::QDepth))
    else $error("output queue overflow");

  // A last item always closes the run; any other item leaves one open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_item_i |=> !run_open_q)
    else $error("run left open after last item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !last_item_i |=> run_open_q)
    else $error("no run open after a non-last item");

  // A last item always yields a record, so the queue cannot be empty next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_item_i |=> out_valid_o)
    else $error("last item produced no record");
`endif

endmodule
